>>> rtl/core/jesf_pkg.sv
package jesf_pkg;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerApp1   = 8'hE1;
  localparam logic [7:0] MarkerSos    = 8'hDA;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam int unsigned TagLen      = 6;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SOI2   = 3'd1,
    PH_HUNT   = 3'd2,
    PH_MARKER = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_HEADER = 3'd6,
    PH_SKIP   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_EXIF     = 3'd0,
    ST_BAD      = 3'd1,
    ST_SOS      = 3'd2,
    ST_EOI      = 3'd3,
    ST_DATA_END = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] exif_start;
    logic [15:0] exif_size;
  } result_t;

  function automatic logic [7:0] exif_tag_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/jesf_in_stage.sv
module jesf_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  jesf_pkg::item_t item_i,
  output logic           valid_o,
  output jesf_pkg::item_t item_o,
  input  logic           take_i
);
  import jesf_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign stall_o = valid_q && !take_i;
  assign valid_d = stall_o ? valid_q : valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/jesf_scan.sv
module jesf_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  jesf_pkg::item_t   item_i,
  input  logic [31:0]      image_size_i,
  output logic             res_valid_o,
  output jesf_pkg::result_t res_o
);
  import jesf_pkg::*;

  phase_e      phase_q, phase_d;
  logic        done_q, done_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  marker_q, marker_d;
  logic [15:0] len_q, len_d;
  logic [31:0] origin_q, origin_d;
  logic [2:0]  matched_q, matched_d;
  logic [16:0] skip_q, skip_d;

  phase_e      ph;
  logic        done;
  logic [31:0] cur;
  logic [7:0]  mk;
  logic [15:0] len;
  logic [31:0] org;
  logic [2:0]  k;
  logic [16:0] skl;
  logic [7:0]  b;

  logic [15:0] len_cur, len_eff;
  logic [16:0] rel, lenp1, skip_cnt, skl_dec;
  logic        skip_fwd;
  logic [32:0] size_x, end_seg, cur4, cur5, app1_end, exif_end;
  logic        seg_end_hit, cur4_hit, cur5_hit, skip_end_hit;
  logic [31:0] skip_target;
  logic        app1_fits, exif_fits, tag_ok, tag_last;

  assign b    = item_i.data_byte;
  assign ph   = item_i.first_byte ? PH_START : phase_q;
  assign done = item_i.first_byte ? 1'b0 : done_q;
  assign cur  = item_i.first_byte ? '0 : pos_q;
  assign mk   = item_i.first_byte ? '0 : marker_q;
  assign len  = item_i.first_byte ? '0 : len_q;
  assign org  = item_i.first_byte ? '0 : origin_q;
  assign k    = item_i.first_byte ? '0 : matched_q;
  assign skl  = item_i.first_byte ? '0 : skip_q;

  always_comb begin
    len_cur      = (ph == PH_LEN_LO) ? {len[15:8], b} : len;
    len_eff      = (len_cur < 16'd2) ? 16'd2 : len_cur;
    rel          = (ph == PH_HEADER) ? (17'd4 + {14'd0, k}) : 17'd3;
    lenp1        = {1'b0, len_eff} + 17'd1;
    skip_fwd     = lenp1 > rel;
    skip_cnt     = skip_fwd ? (lenp1 - rel) : 17'd0;
    skl_dec      = skl - 17'd1;
    size_x       = {1'b0, image_size_i};
    end_seg      = {1'b0, org} + {17'd0, len_eff} + 33'd6;
    cur4         = {1'b0, cur} + 33'd4;
    cur5         = {1'b0, cur} + 33'd5;
    seg_end_hit  = end_seg >= size_x;
    cur4_hit     = cur4 >= size_x;
    cur5_hit     = cur5 >= size_x;
    skip_end_hit = skip_fwd ? seg_end_hit : cur5_hit;
    skip_target  = skip_fwd ? (org + 32'd2 + {16'd0, len_eff}) : (cur + 32'd1);
    app1_end     = {1'b0, org} + 33'd10;
    app1_fits    = app1_end <= size_x;
    exif_end     = {1'b0, org} + 33'd2 + {17'd0, len_cur};
    exif_fits    = (len_cur >= 16'd8) && (exif_end <= size_x);
    tag_ok       = ({29'd0, k} < TagLen) && (b == exif_tag_byte(k));
    tag_last     = ({29'd0, k} + 32'd1) == TagLen;
  end

  always_comb begin
    phase_d   = phase_q;
    done_d    = done_q;
    pos_d     = pos_q;
    marker_d  = marker_q;
    len_d     = len_q;
    origin_d  = origin_q;
    matched_d = matched_q;
    skip_d    = skip_q;
    if (step_i) begin
      phase_d   = ph;
      done_d    = done;
      pos_d     = cur;
      marker_d  = mk;
      len_d     = len;
      origin_d  = org;
      matched_d = k;
      skip_d    = skl;
      if (!done) begin
        pos_d = cur + 32'd1;
        case (ph)
          PH_START: begin
            if (image_size_i < 32'd4 || b != MarkerPrefix) begin
              done_d = 1'b1;
            end else begin
              phase_d = PH_SOI2;
            end
          end
          PH_SOI2, PH_HUNT: begin
            if (ph == PH_SOI2 && b != MarkerSoi) begin
              done_d = 1'b1;
            end else if (ph == PH_HUNT && b == MarkerPrefix) begin
              origin_d = cur;
              phase_d  = PH_MARKER;
            end else if (cur5_hit) begin
              done_d = 1'b1;
            end else begin
              origin_d = cur + 32'd1;
              skip_d   = '0;
              phase_d  = PH_HUNT;
            end
          end
          PH_MARKER: begin
            if (b == MarkerPrefix) begin
              if (cur4_hit) begin
                done_d = 1'b1;
              end else begin
                origin_d = cur;
              end
            end else if (b == MarkerSos || b == MarkerEoi) begin
              done_d = 1'b1;
            end else begin
              marker_d = b;
              phase_d  = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_d   = {b, 8'h00};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO, PH_HEADER: begin
            len_d = len_cur;
            if (ph == PH_LEN_LO && mk == MarkerApp1 && app1_fits) begin
              matched_d = '0;
              phase_d   = PH_HEADER;
            end else if (ph == PH_HEADER && tag_ok && !tag_last) begin
              matched_d = k + 3'd1;
            end else if (ph == PH_HEADER && tag_ok && exif_fits) begin
              matched_d = k + 3'd1;
              done_d    = 1'b1;
            end else begin
              if (ph == PH_HEADER && tag_ok) begin
                matched_d = k + 3'd1;
              end
              if (skip_end_hit) begin
                done_d = 1'b1;
              end else begin
                origin_d = skip_target;
                skip_d   = skip_cnt;
                phase_d  = (skip_cnt != '0) ? PH_SKIP : PH_HUNT;
              end
            end
          end
          PH_SKIP: begin
            skip_d = skl_dec;
            if (skl_dec == '0) begin
              phase_d = PH_HUNT;
            end
          end
          default: begin
            phase_d = ph;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_o      = 1'b0;
    res_o.status     = ST_DATA_END;
    res_o.exif_start = '0;
    res_o.exif_size  = '0;
    if (step_i && !done) begin
      case (ph)
        PH_START: begin
          if (image_size_i < 32'd4 || b != MarkerPrefix) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_BAD;
          end
        end
        PH_SOI2: begin
          if (b != MarkerSoi) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_BAD;
          end else if (cur5_hit) begin
            res_valid_o = 1'b1;
          end
        end
        PH_HUNT: begin
          if (b != MarkerPrefix && cur5_hit) begin
            res_valid_o = 1'b1;
          end
        end
        PH_MARKER: begin
          if (b == MarkerPrefix) begin
            res_valid_o = cur4_hit;
          end else if (b == MarkerSos) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_SOS;
          end else if (b == MarkerEoi) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_EOI;
          end
        end
        PH_LEN_LO: begin
          if (!(mk == MarkerApp1 && app1_fits) && skip_end_hit) begin
            res_valid_o = 1'b1;
          end
        end
        PH_HEADER: begin
          if (tag_ok && tag_last && exif_fits) begin
            res_valid_o      = 1'b1;
            res_o.status     = ST_EXIF;
            res_o.exif_start = app1_end[31:0];
            res_o.exif_size  = len_cur - 16'd8;
          end else if (!(tag_ok && !tag_last) && skip_end_hit) begin
            res_valid_o = 1'b1;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      done_q    <= 1'b0;
      pos_q     <= '0;
      marker_q  <= '0;
      len_q     <= '0;
      origin_q  <= '0;
      matched_q <= '0;
      skip_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      done_q    <= done_d;
      pos_q     <= pos_d;
      marker_q  <= marker_d;
      len_q     <= len_d;
      origin_q  <= origin_d;
      matched_q <= matched_d;
      skip_q    <= skip_d;
    end
  end

endmodule

>>> rtl/core/jesf_out_stage.sv
module jesf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jesf_pkg::result_t res_i,
  output logic             busy_o,
  output logic             valid_o,
  input  logic             stall_i,
  output jesf_pkg::result_t res_o
);
  import jesf_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign busy_o  = valid_q && stall_i;
  assign valid_d = busy_o ? valid_q : load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/core/jpeg_exif_segment_finder_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   data_byte_i, first_byte_i
// out      output     out_valid_o / out_stall_i status_o, exif_start_o, exif_size_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (image_size)
//
// One byte per cycle unless a held result stalls the scan: the scan state machine
// handles a byte while it sits in the input register, and its result is
// registered in the output register.
// Reset clears the scan to expect a start marker and image_size to zero.
// A held result stalls the scan and, through it, the input register.
module jpeg_exif_segment_finder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] exif_start_o,
  output logic [15:0] exif_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import jesf_pkg::*;

  logic [31:0] image_size_q, image_size_d;
  item_t       in_item, scan_item;
  logic        scan_valid, scan_step, out_busy, res_valid;
  result_t     res, out_res;

  assign cfg_ready_o  = 1'b1;
  assign image_size_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : image_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= '0;
    end else begin
      image_size_q <= image_size_d;
    end
  end

  assign in_item.data_byte  = data_byte_i;
  assign in_item.first_byte = first_byte_i;

  jesf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item),
    .valid_o (scan_valid),
    .item_o  (scan_item),
    .take_i  (!out_busy)
  );

  assign scan_step = scan_valid && !out_busy;

  jesf_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (scan_step),
    .item_i       (scan_item),
    .image_size_i (image_size_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  jesf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .busy_o  (out_busy),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign status_o     = out_res.status;
  assign exif_start_o = out_res.exif_start;
  assign exif_size_o  = out_res.exif_size;

endmodule
